// File: hw/rtl/bce_pkg.sv
// Shared types, widths and register codes for the Bezier curve evaluator.
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

    // Default maximum curve degree.
    localparam int MAX_ORDER_DEF = 6;

    // Fixed field widths.
    localparam int ORDER_W    = 3;
    localparam int POINT_W    = 32;
    localparam int T_W        = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Fraction bits of t and of the control points.
    localparam int FRAC_W = 16;

    // Product of a 33-bit point difference and an 18-bit signed view of t.
    localparam int PROD_W = (POINT_W + 1) + (T_W + 1);

    // t equal to 1.0 in Q1.16.
    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    // Half of one LSB after the 16-bit shift, for round to nearest.
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_ORDER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POINT_0     = CFG_IDX_W'(1);

    typedef logic [T_W-1:0] tval_t;

    // Control word that travels down the pipeline with each point set.
    typedef struct packed {
        logic  valid;
        tval_t t;
    } stage_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/bce_cfg_regs.sv
// Configuration register file: curve order and control points.
`timescale 1ns / 1ps
`default_nettype none

module bce_cfg_regs
    import bce_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_wdata,
    output logic [ORDER_W-1:0]                 order_eff,
    output logic [MAX_ORDER:0][POINT_W-1:0]    points
);

    logic [ORDER_W-1:0]              order_reg;
    logic [MAX_ORDER:0][POINT_W-1:0] points_reg;

    // Register writes; indexes past the stored points are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= '0;
            points_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CURVE_ORDER)
            begin
                order_reg <= cfg_wdata[ORDER_W-1:0];
            end
            for (int i = 0; i <= MAX_ORDER; i++)
            begin
                if (cfg_index == REG_POINT_0 + CFG_IDX_W'(i))
                begin
                    points_reg[i] <= cfg_wdata[POINT_W-1:0];
                end
            end
        end
    end

    // An order above the supported maximum is clamped to it.
    assign order_eff = (order_reg > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_reg;
    assign points    = points_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bce_lerp_stage.sv
// One de Casteljau level: rounded linear interpolation of neighboring points.
`timescale 1ns / 1ps
`default_nettype none

module bce_lerp_stage
    import bce_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int STAGE_IDX = 1
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ORDER_W-1:0]              order_eff,
    input  stage_ctrl_t                     ctrl_in,
    input  logic [MAX_ORDER:0][POINT_W-1:0] pts_in,
    output stage_ctrl_t                     ctrl_out,
    output logic [MAX_ORDER:0][POINT_W-1:0] pts_out
);

    // This level reads NUM_IN points and produces one fewer.
    localparam int NUM_IN  = MAX_ORDER + 2 - STAGE_IDX;
    localparam int NUM_OUT = NUM_IN - 1;

    // Levels up to this order only pass the low points through.
    localparam logic [ORDER_W-1:0] PASS_LIMIT = ORDER_W'(MAX_ORDER - STAGE_IDX);

    stage_ctrl_t                      mid_ctrl_reg;
    logic                             active_reg;
    logic signed [POINT_W-1:0]        base_reg [NUM_OUT];
    logic signed [PROD_W-1:0]         prod_reg [NUM_OUT];
    logic signed [PROD_W-1:0]         prod_next [NUM_OUT];

    stage_ctrl_t                      out_ctrl_reg;
    logic [NUM_OUT-1:0][POINT_W-1:0]  res_reg;
    logic [NUM_OUT-1:0][POINT_W-1:0]  res_next;

    // First step: difference of neighbors times t.
    always_comb
    begin
        for (int i = 0; i < NUM_OUT; i++)
        begin
            prod_next[i] = PROD_W'($signed({pts_in[i+1][POINT_W-1], pts_in[i+1]})
                                   - $signed({pts_in[i][POINT_W-1], pts_in[i]}))
                           * PROD_W'($signed({1'b0, ctrl_in.t}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_ctrl_reg <= '0;
        end
        else
        begin
            mid_ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        active_reg <= (order_eff > PASS_LIMIT);
        for (int i = 0; i < NUM_OUT; i++)
        begin
            base_reg[i] <= pts_in[i];
            prod_reg[i] <= prod_next[i];
        end
    end

    // Second step: round to nearest, ties up, and add to the lower point.
    always_comb
    begin
        logic signed [PROD_W-1:0] sum;
        for (int i = 0; i < NUM_OUT; i++)
        begin
            sum = prod_reg[i] + ROUND_HALF;
            if (active_reg)
            begin
                res_next[i] = base_reg[i] + sum[FRAC_W+POINT_W-1:FRAC_W];
            end
            else
            begin
                res_next[i] = base_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctrl_reg <= '0;
        end
        else
        begin
            out_ctrl_reg <= mid_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Points above this level's count are unused and read as zero.
    always_comb
    begin
        pts_out = '0;
        pts_out[NUM_OUT-1:0] = res_reg;
    end

    assign ctrl_out = out_ctrl_reg;

endmodule

`default_nettype wire

// File: hw/rtl/bezier_curve_evaluator_unit.sv
// Top level of the pipelined Bezier curve evaluator.
//
// Usage:
//   Input channel: a word (param_t, unsigned Q1.16, values above 1.0 clamp
//   to 1.0) is taken at each rising edge where start is high and busy is
//   low. busy is always low, so one word can enter on every cycle.
//   Result channel: done is high for exactly one cycle while curve_value
//   (signed Q16.16) holds the curve at that t. The receiver cannot stall.
//   Path: an accepted word passes the input register and then both
//   registers of each level before it reaches done and curve_value.
//   Throughput: one word per cycle. Each of the MAX_ORDER de Casteljau
//   levels is a two-register stage (multiply, then round and add); levels
//   above the programmed order pass points through unchanged.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 is the
//   order, 1 to MAX_ORDER + 1 the control points); write only while no word is in
//   flight. Writes to other indexes are ignored.
//   Reset: rst_n clears the order, the points and every valid bit in the
//   pipeline; words in flight are dropped.
`timescale 1ns / 1ps
`default_nettype none

module bezier_curve_evaluator_unit
    import bce_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [T_W-1:0]            param_t,
    output logic                      busy,
    output logic                      done,
    output logic signed [POINT_W-1:0] curve_value,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

    logic [ORDER_W-1:0]                            order_eff;
    logic [MAX_ORDER:0][MAX_ORDER:0][POINT_W-1:0]  pts_bus;
    stage_ctrl_t                                   ctrl_bus [MAX_ORDER+1];
    stage_ctrl_t                                   in_ctrl_reg;
    stage_ctrl_t                                   in_ctrl_next;

    // Configuration registers.
    bce_cfg_regs #(
        .MAX_ORDER (MAX_ORDER)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .order_eff (order_eff),
        .points    (pts_bus[0])
    );

    // Input register with t clamped to one.
    always_comb
    begin
        in_ctrl_next.valid = start & ~busy;
        in_ctrl_next.t     = (param_t > T_ONE) ? T_ONE : param_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctrl_reg <= '0;
        end
        else
        begin
            in_ctrl_reg <= in_ctrl_next;
        end
    end

    assign ctrl_bus[0] = in_ctrl_reg;

    // Chain of interpolation levels.
    for (genvar s = 1; s <= MAX_ORDER; s++)
    begin : g_level
        bce_lerp_stage #(
            .MAX_ORDER (MAX_ORDER),
            .STAGE_IDX (s)
        ) u_level (
            .clk       (clk),
            .rst_n     (rst_n),
            .order_eff (order_eff),
            .ctrl_in   (ctrl_bus[s-1]),
            .pts_in    (pts_bus[s-1]),
            .ctrl_out  (ctrl_bus[s]),
            .pts_out   (pts_bus[s])
        );
    end

    // The pipeline never refuses a word.
    assign busy        = 1'b0;
    assign done        = ctrl_bus[MAX_ORDER].valid;
    assign curve_value = pts_bus[MAX_ORDER][0];

endmodule

`default_nettype wire

// File: hw/rtl/bce_checker.sv
// Port-level checker for the Bezier curve evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bce_checker
    import bce_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [T_W-1:0]            param_t,
    input  logic                      busy,
    input  logic                      done,
    input  logic signed [POINT_W-1:0] curve_value,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int LATENCY = 2 * MAX_ORDER + 1;

    logic [POINT_W-1:0] p0_reg;

    // Shadow copy of the first control point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg <= '0;
        end
        else if (cfg_we && cfg_index == REG_POINT_0)
        begin
            p0_reg <= cfg_wdata[POINT_W-1:0];
        end
    end

    // Every accepted word gives a result after the fixed latency.
    a_accept_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted word produced no result");

    // No result appears without a word accepted the latency earlier.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted word");

    // The start of the curve is exactly the first control point.
    a_t_zero_is_p0: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && param_t == '0) |-> ##LATENCY (curve_value == p0_reg))
        else $error("curve at t of zero differs from the first point");

endmodule

bind bezier_curve_evaluator_unit bce_checker #(
    .MAX_ORDER (MAX_ORDER)
) u_bce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .param_t     (param_t),
    .busy        (busy),
    .done        (done),
    .curve_value (curve_value),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
);

`default_nettype wire
